/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. Define NO_ASSERTIONS to drop them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(name, clk, rst_n, prop, msg)
`define ASSERT_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

/* rtl/core/ssb_pkg.sv */
// ---------------------------------------------------------------------------
// ssb_pkg
// Types and constants shared by the stopwatch statistics bank.
// ---------------------------------------------------------------------------
package ssb_pkg;

    localparam int NUM_TIMERS_DEF = 64;
    localparam int DEPTH_BITS_DEF = 8;
    localparam int IDX_W          = 6;
    localparam int STAMP_W        = 64;
    localparam int COUNT_W        = 32;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_STOP  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic [IDX_W-1:0]   timer_index;
        logic [STAMP_W-1:0] time_now;
    } in_word_t;

    typedef struct packed {
        logic               error;
        logic               running;
        logic [STAMP_W-1:0] interval_total;
        logic [COUNT_W-1:0] interval_number;
        logic [STAMP_W-1:0] interval_min;
        logic [STAMP_W-1:0] interval_max;
    } out_word_t;

    // Per-timer statistics as kept in the memory
    typedef struct packed {
        logic [STAMP_W-1:0] sum_time;
        logic [COUNT_W-1:0] done_count;
        logic [STAMP_W-1:0] low_time;
        logic [STAMP_W-1:0] high_time;
    } stats_t;

    localparam int STATS_W = $bits(stats_t);

    // Controller to datapath
    typedef struct packed {
        logic accept;     // input word taken, memory read issued
        logic span_load;  // read data valid, latch entry and interval
        logic commit;     // write back entry, load output register
        logic clear_wr;   // clearing pass write
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_valid;
        logic out_ready;
    } ctrl_stat_t;

endpackage

/* rtl/core/ssb_ram.sv */
// ---------------------------------------------------------------------------
// ssb_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ssb_ram #(
    parameter int  WIDTH  = 8,
    parameter int  DEPTH  = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/ssb_ctrl.sv */
// ---------------------------------------------------------------------------
// ssb_ctrl
// Sequencer: clearing pass after reset, then accept / fetch / update per word.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ssb_ctrl #(
    parameter int  NUM_TIMERS = 64,
    localparam int ADDR_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ssb_pkg::ctrl_stat_t stat,
    output ssb_pkg::ctrl_cmd_t  cmd,
    output logic [ADDR_W-1:0]   clear_addr
);

    import ssb_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_UPDATE
    } state_t;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_TIMERS - 1);

    state_t            state_reg;
    state_t            state_next;
    logic [ADDR_W-1:0] clear_addr_reg;
    logic [ADDR_W-1:0] clear_addr_next;
    logic              out_free;

    assign out_free = !stat.out_valid || stat.out_ready;

    always_comb
    begin
        state_next      = state_reg;
        clear_addr_next = clear_addr_reg;
        cmd             = '0;
        in_ready        = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr    = 1'b1;
                clear_addr_next = clear_addr_reg + 1'b1;
                if (clear_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.span_load = 1'b1;
                state_next    = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // hold until the output register can take the result
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clear_addr_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clear_addr_reg <= clear_addr_next;
        end
    end

    assign clear_addr = clear_addr_reg;

    `ASSERT_NEVER(a_commit_overrun, clk, rst_n, cmd.commit && stat.out_valid && !stat.out_ready, "commit while output word still pending")
    `ASSERT_PROP(a_accept_then_load, clk, rst_n, cmd.accept |=> cmd.span_load, "read data not latched after accept")
    `ASSERT_NEVER(a_clear_accept, clk, rst_n, cmd.clear_wr && (in_ready || cmd.commit), "input or commit during clearing pass")

endmodule

/* rtl/core/ssb_dpath.sv */
// ---------------------------------------------------------------------------
// ssb_dpath
// Timer memory, interval arithmetic and output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ssb_dpath #(
    parameter int  NUM_TIMERS = 64,
    parameter int  DEPTH_BITS = 8,
    localparam int ADDR_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ssb_pkg::ctrl_cmd_t cmd,
    input  logic [ADDR_W-1:0]  clear_addr,
    input  ssb_pkg::in_word_t  in_data,
    output ssb_pkg::ctrl_stat_t stat,
    output logic               out_valid,
    input  logic               out_ready,
    output ssb_pkg::out_word_t out_data
);

    import ssb_pkg::*;

    localparam int ENTRY_W = DEPTH_BITS + STAMP_W + STATS_W;

    logic [ADDR_W+IDX_W-1:0] idx_ext;
    logic [ADDR_W-1:0]       in_addr;
    logic                    in_range;

    logic [1:0]            cmd_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic                  range_reg;
    logic [STAMP_W-1:0]    now_reg;
    logic [DEPTH_BITS-1:0] depth_reg;
    logic [STAMP_W-1:0]    start_reg;
    stats_t                stats_reg;
    logic [STAMP_W-1:0]    span_reg;

    logic [ENTRY_W-1:0]    rd_data;
    logic [DEPTH_BITS-1:0] rd_depth;
    logic [STAMP_W-1:0]    rd_start;
    stats_t                rd_stats;

    logic                  is_start;
    logic                  is_stop;
    logic                  err;
    logic                  finish;
    logic [DEPTH_BITS-1:0] depth_new;
    logic [STAMP_W-1:0]    start_new;
    stats_t                stats_new;
    out_word_t             result;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_wr_addr;
    logic [ENTRY_W-1:0]    ram_wr_data;

    logic                  out_valid_reg;
    out_word_t             out_reg;

    assign idx_ext  = (ADDR_W + IDX_W)'(in_data.timer_index);
    assign in_addr  = idx_ext[ADDR_W-1:0];
    assign in_range = 32'(in_data.timer_index) < 32'(NUM_TIMERS);

    assign rd_depth = rd_data[ENTRY_W-1 -: DEPTH_BITS];
    assign rd_start = rd_data[STATS_W +: STAMP_W];
    assign rd_stats = stats_t'(rd_data[STATS_W-1:0]);

    // capture the word on accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            range_reg <= in_range;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cmd_reg  <= in_data.command;
            addr_reg <= in_addr;
            now_reg  <= in_data.time_now;
        end
        if (cmd.span_load)
        begin
            depth_reg <= rd_depth;
            start_reg <= rd_start;
            stats_reg <= rd_stats;
            span_reg  <= now_reg - rd_start;
        end
    end

    always_comb
    begin
        is_start  = (cmd_reg == CMD_START);
        is_stop   = (cmd_reg == CMD_STOP);
        err       = (is_start && (depth_reg == '1)) || (is_stop && (depth_reg == '0));
        depth_new = depth_reg;
        start_new = start_reg;
        stats_new = stats_reg;
        finish    = 1'b0;
        if (is_start && !err)
        begin
            depth_new = depth_reg + 1'b1;
            if (depth_reg == '0)
            begin
                start_new = now_reg;
            end
        end
        else if (is_stop && !err)
        begin
            depth_new = depth_reg - 1'b1;
            finish    = (depth_reg == DEPTH_BITS'(1));
        end
        if (finish)
        begin
            stats_new.sum_time = stats_reg.sum_time + span_reg;
            if (stats_reg.done_count == '0)
            begin
                stats_new.low_time  = span_reg;
                stats_new.high_time = span_reg;
            end
            else
            begin
                if (span_reg < stats_reg.low_time)
                begin
                    stats_new.low_time = span_reg;
                end
                if (span_reg > stats_reg.high_time)
                begin
                    stats_new.high_time = span_reg;
                end
            end
            // saturate the interval count
            if (stats_reg.done_count != '1)
            begin
                stats_new.done_count = stats_reg.done_count + 1'b1;
            end
        end

        result = '0;
        if (range_reg)
        begin
            result.error           = err;
            result.running         = (depth_new != '0);
            result.interval_total  = stats_new.sum_time;
            result.interval_number = stats_new.done_count;
            result.interval_min    = stats_new.low_time;
            result.interval_max    = stats_new.high_time;
        end
        else
        begin
            result.error = 1'b1;
        end
    end

    assign ram_we      = cmd.clear_wr || (cmd.commit && range_reg);
    assign ram_wr_addr = cmd.clear_wr ? clear_addr : addr_reg;
    assign ram_wr_data = cmd.clear_wr ? '0 : {depth_new, start_new, stats_new};

    ssb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_TIMERS)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.accept),
        .rd_addr (in_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_data       = out_reg;
    assign stat.out_valid = out_valid_reg;
    assign stat.out_ready = out_ready;

    `ASSERT_PROP(a_commit_shows, clk, rst_n, cmd.commit |=> out_valid, "committed word not presented")
    `ASSERT_PROP(a_range_error, clk, rst_n, (cmd.commit && !range_reg) |=> (out_data.error && !out_data.running && (out_data.interval_number == '0)), "out-of-range word not flagged")

endmodule

/* rtl/core/stopwatch_stats_bank.sv */
// ---------------------------------------------------------------------------
// stopwatch_stats_bank
// Bank of nestable profiling stopwatches with per-timer interval statistics.
// ---------------------------------------------------------------------------
// Each input word names a timer, a command (start, stop, read) and the
// current timestamp; each one returns exactly one word with the timer's
// error flag, running flag, total, count, min and max after the command.
// A word passes through accept with the memory read issued, latch of
// the timer entry together with the interval subtraction, then update and
// write-back into the output register. The sequence is set by the per-timer
// read-modify-write through the timer memory and its registered read port.
// The next word is accepted the cycle after write-back, even while the
// previous result still waits in the output register; the update stalls
// only if that register is still full. After reset the block sweeps the
// timer memory to zero, one timer per cycle, with in_ready low.
// Timer indexes not below NUM_TIMERS return error with all other fields zero.
// ---------------------------------------------------------------------------
module stopwatch_stats_bank #(
    parameter int NUM_TIMERS = ssb_pkg::NUM_TIMERS_DEF,
    parameter int DEPTH_BITS = ssb_pkg::DEPTH_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ssb_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ssb_pkg::out_word_t out_data
);

    import ssb_pkg::*;

    localparam int ADDR_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    ctrl_cmd_t         cmd;
    ctrl_stat_t        stat;
    logic [ADDR_W-1:0] clear_addr;

    ssb_ctrl #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .stat       (stat),
        .cmd        (cmd),
        .clear_addr (clear_addr)
    );

    ssb_dpath #(
        .NUM_TIMERS (NUM_TIMERS),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .clear_addr (clear_addr),
        .in_data    (in_data),
        .stat       (stat),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

/* verif/stopwatch_stats_bank_test.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// stopwatch_stats_bank_test
// Self-checking bench for the stopwatch statistics bank. Drives start, stop
// and read words through the valid/ready input, predicts every timer's
// depth and statistics, and compares each output word field by field.
// ---------------------------------------------------------------------------
module stopwatch_stats_bank_test;

    import ssb_pkg::*;

    localparam int                  CYCLE_LIMIT  = 200000;
    localparam int                  HOLD_CYCLES  = 400;
    localparam int                  DEEP_COUNT   = 260;
    localparam logic [1:0]          CMD_READ_ALT = 2'd3;
    localparam logic [IDX_W-1:0]    DEEP_TIMER   = 6'd40;
    localparam logic [DEPTH_BITS_DEF-1:0] DEPTH_LIMIT = '1;
    localparam logic [COUNT_W-1:0]  COUNT_FULL   = '1;

    // Tracks every timer and holds the words the block owes us, oldest first
    class timer_stats_model;
        logic [DEPTH_BITS_DEF-1:0] depth [NUM_TIMERS_DEF];
        logic [STAMP_W-1:0]        stamp [NUM_TIMERS_DEF];
        logic [STAMP_W-1:0]        total [NUM_TIMERS_DEF];
        logic [STAMP_W-1:0]        shortest [NUM_TIMERS_DEF];
        logic [STAMP_W-1:0]        longest [NUM_TIMERS_DEF];
        logic [COUNT_W-1:0]        count [NUM_TIMERS_DEF];
        out_word_t                 expected_words [$];
        int                        fail_count;

        function new();
            foreach (depth[k])
            begin
                depth[k]    = '0;
                stamp[k]    = '0;
                total[k]    = '0;
                shortest[k] = '0;
                longest[k]  = '0;
                count[k]    = '0;
            end
            fail_count = 0;
        endfunction

        function void note_word(in_word_t w);
            out_word_t          r;
            int                 k;
            logic [STAMP_W-1:0] span;
            r = '0;
            if (w.timer_index >= NUM_TIMERS_DEF)
            begin
                r.error = 1'b1;
                expected_words.push_back(r);
                return;
            end
            k = int'(w.timer_index);
            case (w.command)
                CMD_START:
                begin
                    if (depth[k] == DEPTH_LIMIT)
                        r.error = 1'b1;
                    else
                    begin
                        depth[k]++;
                        // latch the stamp on the outermost start only
                        if (depth[k] == 1)
                            stamp[k] = w.time_now;
                    end
                end
                CMD_STOP:
                begin
                    if (depth[k] == 0)
                        r.error = 1'b1;
                    else
                    begin
                        depth[k]--;
                        if (depth[k] == 0)
                        begin
                            span     = w.time_now - stamp[k];
                            total[k] = total[k] + span;
                            if (count[k] == 0)
                            begin
                                shortest[k] = span;
                                longest[k]  = span;
                            end
                            else
                            begin
                                if (span < shortest[k])
                                    shortest[k] = span;
                                if (span > longest[k])
                                    longest[k] = span;
                            end
                            if (count[k] != COUNT_FULL)
                                count[k]++;
                        end
                    end
                end
                default: ;
            endcase
            r.running         = (depth[k] != 0);
            r.interval_total  = total[k];
            r.interval_number = count[k];
            r.interval_min    = shortest[k];
            r.interval_max    = longest[k];
            expected_words.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
                fail_count++;
            end
        endfunction

        function void check_word(out_word_t got);
            out_word_t want;
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected output word, expected none actual %h", $time, got);
                fail_count++;
                return;
            end
            want = expected_words.pop_front();
            compare_field("error", 64'(want.error), 64'(got.error));
            compare_field("running", 64'(want.running), 64'(got.running));
            compare_field("interval_total", want.interval_total, got.interval_total);
            compare_field("interval_number", 64'(want.interval_number),
                          64'(got.interval_number));
            compare_field("interval_min", want.interval_min, got.interval_min);
            compare_field("interval_max", want.interval_max, got.interval_max);
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_word_t out_data;

    timer_stats_model   sb;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    logic               want_hold;
    logic               hold_done;
    int                 hold_left;
    int                 cycle_count;
    logic [STAMP_W-1:0] time_base;

    stopwatch_stats_bank u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Output side: check accepted words, then pick ready for the next edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_word(out_data);
        if (want_hold && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [STAMP_W-1:0] next_stamp();
        // mostly a rising clock; now and then a jump anywhere
        if ($urandom_range(15) == 0)
            time_base = {$urandom, $urandom};
        else
            time_base = time_base + $urandom_range(1, 4000);
        return time_base;
    endfunction

    // Offer one word and hold it until accepted; called at a rising edge
    task automatic send_command(logic [1:0] cmd, logic [IDX_W-1:0] idx,
                                logic [STAMP_W-1:0] stamp);
        in_word_t w;
        w.command     = cmd;
        w.timer_index = idx;
        w.time_now    = stamp;
        // decide at each edge whether to idle, at the idle rate
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_word(w);
    endtask

    task automatic run_random(int n);
        int               i;
        int               pick;
        logic [1:0]       cmd;
        logic [IDX_W-1:0] idx;
        for (i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 42)
                cmd = CMD_START;
            else if (pick < 84)
                cmd = CMD_STOP;
            else if (pick < 96)
                cmd = CMD_READ;
            else
                cmd = CMD_READ_ALT;
            // a few hot timers give nesting and back-to-back hits
            if ($urandom_range(3) == 0)
                idx = IDX_W'($urandom_range(NUM_TIMERS_DEF - 1));
            else
                idx = IDX_W'($urandom_range(3));
            send_command(cmd, idx, next_stamp());
        end
    endtask

    initial
    begin
        int i;
        sb            = new();
        send_idle_pct = 29;
        recv_idle_pct = 67;
        want_hold     = 1'b0;
        hold_done     = 1'b0;
        hold_left     = 0;
        cycle_count   = 0;
        time_base     = 64'hFFFF_FFFF_FFFF_0000;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_ready <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        send_command(CMD_READ, 6'd0, 64'd0);
        send_command(CMD_STOP, 6'd5, 64'd1);
        send_command(CMD_START, 6'd63, 64'd0);
        send_command(CMD_STOP, 6'd63, '1);
        // total wraps past 2^64
        send_command(CMD_START, 6'd63, 64'd10);
        send_command(CMD_STOP, 6'd63, 64'd12);
        // interval across the timestamp wrap
        send_command(CMD_START, 6'd1, '1);
        send_command(CMD_STOP, 6'd1, 64'd5);
        // nested start keeps the stamp, inner stop records nothing
        send_command(CMD_START, 6'd2, 64'd100);
        send_command(CMD_START, 6'd2, 64'd200);
        send_command(CMD_STOP, 6'd2, 64'd300);
        send_command(CMD_READ_ALT, 6'd2, '1);
        send_command(CMD_STOP, 6'd2, 64'd1000);
        send_command(CMD_START, 6'd2, 64'd1000);
        send_command(CMD_STOP, 6'd2, 64'd1000);
        send_command(CMD_START, 6'd2, 64'd0);
        send_command(CMD_STOP, 6'd2, 64'd5000);
        send_command(CMD_STOP, 6'd2, 64'd7);
        send_command(CMD_READ, 6'd63, 64'd0);

        run_random(130);

        send_idle_pct = 67;
        recv_idle_pct = 29;
        run_random(130);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // stall the output while the sender keeps pushing
        want_hold = 1'b1;
        for (i = 0; i < DEEP_COUNT; i++)
            send_command(CMD_START, DEEP_TIMER, next_stamp());
        for (i = 0; i < DEEP_COUNT; i++)
            send_command(CMD_STOP, DEEP_TIMER, next_stamp());
        run_random(130);
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
